### design/ttc_pkg.sv
// ttc_pkg: shared types and constants for the text-mode teletype console
// holds the transfer payload structs, command and state codes, character codes
// no dependencies

package ttc_pkg;

  // field widths fixed by the transfer formats
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int LINEAR_W = 11;

  typedef logic [15:0] cell_t;
  typedef logic [3:0]  colour_t;

  // command codes, codes 5 to 7 do nothing
  typedef enum logic [2:0] {
    CMD_TELETYPE  = 3'd0,
    CMD_WRITE     = 3'd1,
    CMD_CLEAR     = 3'd2,
    CMD_SET_CURSOR = 3'd3,
    CMD_READ      = 3'd4
  } cmd_code_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_FOREGROUND = 1'b0,
    CFG_BACKGROUND = 1'b1
  } cfg_reg_t;

  // character codes and tab constants
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] TAB_STEP     = 8'd8;
  localparam logic [7:0] TAB_MASK     = ~8'd7;

  // light grey space on black, the power-up contents
  localparam cell_t RESET_CELL = 16'h0720;

  localparam colour_t FG_RESET = 4'd7;
  localparam colour_t BG_RESET = 4'd0;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_EXEC,
    ST_TAB,
    ST_SCROLL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]       command;
    logic [7:0]       char_code;
    logic [7:0]       attr_byte;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] line;
  } ttc_cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]    cursor_column;
    logic [ROW_W-1:0]    cursor_line;
    logic [LINEAR_W-1:0] cursor_linear;
    logic [7:0]          read_char;
    logic [7:0]          read_attr;
  } ttc_res_t;

endpackage

### design/ttc_cell_ram.sv
// ttc_cell_ram: character cell store, one write port and one read port
// read data is registered and holds until the next read
// depends on ttc_pkg

module ttc_cell_ram #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  ttc_pkg::cell_t    wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output ttc_pkg::cell_t    rd_data
);
  import ttc_pkg::*;

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/text_mode_teletype_console.sv
// text_mode_teletype_console: console engine over a cell grid held in one ram
// commands are handled one at a time: a new one is taken when idle or as the last
//   result is published; tab, scroll and clear run through extra states first
// reset: synchronous; a clearing pass writes the power-up cell, cmd_stall high
// depends on ttc_pkg, ttc_cell_ram

module text_mode_teletype_console #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input  logic              clk,
  input  logic              rst,
  // command channel
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  ttc_pkg::ttc_cmd_t cmd_item,
  // result channel
  output logic              res_valid,
  input  logic              res_stall,
  output ttc_pkg::ttc_res_t res_item,
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  ttc_pkg::cfg_reg_t cfg_index,
  input  ttc_pkg::colour_t  cfg_data
);
  import ttc_pkg::*;

  // geometry
  localparam int CELL_COUNT  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int SCROLL_LAST = (SCREEN_HEIGHT - 1) * SCREEN_WIDTH;
  localparam int ADDR_W      = $clog2(CELL_COUNT);
  localparam int PTR_W       = $clog2(CELL_COUNT + 1);
  localparam int LIN_W       = (PTR_W > LINEAR_W) ? PTR_W : LINEAR_W;

  localparam logic [COL_W:0]   W_LIM   = (COL_W + 1)'(SCREEN_WIDTH);
  localparam logic [COL_W-1:0] COL_MAX = COL_W'(SCREEN_WIDTH - 1);
  localparam logic [ROW_W:0]   H_LIM   = (ROW_W + 1)'(SCREEN_HEIGHT);
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(SCREEN_HEIGHT - 1);
  localparam logic [PTR_W-1:0] PTR_STEP = PTR_W'(SCREEN_WIDTH);
  localparam logic [PTR_W-1:0] PTR_SCROLL_END = PTR_W'(SCROLL_LAST);
  localparam logic [PTR_W-1:0] PTR_FILL_END = PTR_W'(CELL_COUNT - 1);

  // row-major cell index, its result is used only for positions on the grid
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    logic [LIN_W-1:0] t;
    t = LIN_W'(r) * LIN_W'(SCREEN_WIDTH) + LIN_W'(c);
    return t[ADDR_W-1:0];
  endfunction

  // control and cursor state
  state_t             state, state_next;
  logic [COL_W-1:0]   cursor_col, cursor_col_next;
  logic [ROW_W-1:0]   cursor_row, cursor_row_next;
  logic [PTR_W-1:0]   ptr, ptr_next;
  logic               init_pass, init_pass_next;
  logic               res_valid_next;
  colour_t            foreground_colour, background_colour;

  // payload registers
  ttc_cmd_t           item, item_next;
  ttc_res_t           res_next;
  logic [COL_W:0]     tab_stop, tab_stop_next;
  logic               rd_hit, rd_hit_next;

  // ram ports
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  cell_t              wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  cell_t              rd_data;

  // decode helpers
  cell_t              blank;
  logic               done_free;
  logic [COL_W:0]     col_ext;
  logic [COL_W:0]     col_p1;
  logic [ROW_W:0]     row_p1;
  logic               pos_on_grid;
  logic [ADDR_W-1:0]  pos_addr;
  logic               advance_row;
  logic [LIN_W-1:0]   linear;
  logic [PTR_W-1:0]   ptr_ahead;
  logic [PTR_W-1:0]   ptr_behind;

  assign cfg_ready = 1'b1;

  assign blank       = {background_colour, foreground_colour, CH_SPACE};
  assign col_ext     = {1'b0, cursor_col};
  assign col_p1      = col_ext + (COL_W + 1)'(1);
  assign row_p1      = {1'b0, cursor_row} + (ROW_W + 1)'(1);
  assign pos_on_grid = ({1'b0, item.column} < W_LIM) && ({1'b0, item.line} < H_LIM);
  assign pos_addr    = cell_addr(item.line, item.column);
  assign linear      = LIN_W'(cursor_row) * LIN_W'(SCREEN_WIDTH) + LIN_W'(cursor_col);
  assign ptr_ahead   = ptr + PTR_STEP;
  assign ptr_behind  = ptr - PTR_W'(1);

  // the result register is free when empty or its transfer happens now
  assign done_free = !res_valid || !res_stall;

  // new commands are taken when idle, or as the finished one is published
  assign cmd_stall = !((state == ST_IDLE) || ((state == ST_DONE) && done_free));

  ttc_cell_ram #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_FILL;
      cursor_col        <= '0;
      cursor_row        <= '0;
      ptr               <= '0;
      init_pass         <= 1'b1;
      res_valid         <= 1'b0;
      foreground_colour <= FG_RESET;
      background_colour <= BG_RESET;
    end else begin
      state      <= state_next;
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
      ptr        <= ptr_next;
      init_pass  <= init_pass_next;
      res_valid  <= res_valid_next;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FOREGROUND: foreground_colour <= cfg_data;
          CFG_BACKGROUND: background_colour <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item     <= item_next;
    tab_stop <= tab_stop_next;
    rd_hit   <= rd_hit_next;
    if (state == ST_DONE && done_free) begin
      res_item <= res_next;
    end
  end

  always_comb begin
    state_next      = state;
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    ptr_next        = ptr;
    init_pass_next  = init_pass;
    item_next       = item;
    tab_stop_next   = tab_stop;
    rd_hit_next     = rd_hit;
    res_valid_next  = res_valid && res_stall;
    advance_row     = 1'b0;

    wr_en   = 1'b0;
    wr_addr = pos_addr;
    wr_data = blank;
    rd_en   = 1'b0;
    rd_addr = pos_addr;

    res_next.cursor_column = cursor_col;
    res_next.cursor_line   = cursor_row;
    res_next.cursor_linear = linear[LINEAR_W-1:0];
    res_next.read_char     = rd_hit ? rd_data[7:0] : 8'd0;
    res_next.read_attr     = rd_hit ? rd_data[15:8] : 8'd0;

    case (state)
      // linear fill: power-up pass, clear, or blank bottom row after a scroll
      ST_FILL: begin
        wr_en   = 1'b1;
        wr_addr = ptr[ADDR_W-1:0];
        wr_data = init_pass ? RESET_CELL : blank;
        if (ptr == PTR_FILL_END) begin
          init_pass_next = 1'b0;
          state_next     = init_pass ? ST_IDLE : ST_DONE;
        end else begin
          ptr_next = ptr + PTR_W'(1);
        end
      end

      ST_IDLE: begin
        if (cmd_valid) begin
          item_next  = cmd_item;
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_next  = ST_DONE;
        rd_hit_next = 1'b0;
        case (cmd_code_t'(item.command))
          CMD_TELETYPE: begin
            case (item.char_code)
              CH_NEWLINE: begin
                advance_row = 1'b1;
              end
              CH_RETURN: begin
                cursor_col_next = '0;
              end
              CH_BACKSPACE: begin
                // column may sit at the width after a tab, still one left is on grid
                if (cursor_col != '0) begin
                  cursor_col_next = cursor_col - COL_W'(1);
                  wr_en   = 1'b1;
                  wr_addr = cell_addr(cursor_row, cursor_col - COL_W'(1));
                end
              end
              CH_TAB: begin
                tab_stop_next = (col_ext + TAB_STEP) & TAB_MASK;
                state_next    = ST_TAB;
              end
              default: begin
                // printable byte, dropped when the cursor is past the right edge
                if (col_ext < W_LIM) begin
                  wr_en   = 1'b1;
                  wr_addr = cell_addr(cursor_row, cursor_col);
                  wr_data = {background_colour, foreground_colour, item.char_code};
                end
                if (col_p1 >= W_LIM) begin
                  advance_row = 1'b1;
                end else begin
                  cursor_col_next = col_p1[COL_W-1:0];
                end
              end
            endcase
            // wrap to the next row, scrolling when the bottom is passed
            if (advance_row) begin
              cursor_col_next = '0;
              if (row_p1 >= H_LIM) begin
                cursor_row_next = ROW_MAX;
                ptr_next        = '0;
                state_next      = ST_SCROLL;
              end else begin
                cursor_row_next = row_p1[ROW_W-1:0];
              end
            end
          end
          CMD_WRITE: begin
            if (pos_on_grid) begin
              wr_en   = 1'b1;
              wr_data = {item.attr_byte, item.char_code};
            end
          end
          CMD_CLEAR: begin
            cursor_col_next = '0;
            cursor_row_next = '0;
            ptr_next        = '0;
            state_next      = ST_FILL;
          end
          CMD_SET_CURSOR: begin
            cursor_col_next = ({1'b0, item.column} < W_LIM) ? item.column : COL_MAX;
            cursor_row_next = ({1'b0, item.line} < H_LIM) ? item.line : ROW_MAX;
          end
          CMD_READ: begin
            // ram read lands in rd_data for the publish cycle
            if (pos_on_grid) begin
              rd_en       = 1'b1;
              rd_hit_next = 1'b1;
            end
          end
          default: ;
        endcase
      end

      // one blank per cycle up to the tab stop or the right edge
      ST_TAB: begin
        if ((col_ext < tab_stop) && (col_ext < W_LIM)) begin
          wr_en           = 1'b1;
          wr_addr         = cell_addr(cursor_row, cursor_col);
          cursor_col_next = col_p1[COL_W-1:0];
        end else begin
          state_next = ST_DONE;
        end
      end

      // copy cell ptr+W to ptr, each write stores the cell read in the cycle before
      ST_SCROLL: begin
        if (ptr != PTR_SCROLL_END) begin
          rd_en    = 1'b1;
          rd_addr  = ptr_ahead[ADDR_W-1:0];
          ptr_next = ptr + PTR_W'(1);
        end else begin
          state_next = ST_FILL;
        end
        if (ptr != '0) begin
          wr_en   = 1'b1;
          wr_addr = ptr_behind[ADDR_W-1:0];
          wr_data = rd_data;
        end
      end

      // publish the result, taking the next command in the same cycle
      ST_DONE: begin
        if (done_free) begin
          res_valid_next = 1'b1;
          if (cmd_valid) begin
            item_next  = cmd_item;
            state_next = ST_EXEC;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // cursor row never leaves the grid
  a_row_on_grid: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, cursor_row} < H_LIM))
    else $error("cursor row beyond the bottom row");

  // a new result only comes out of the publish state
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside publish state");

  // an idle block leaves the store alone
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !wr_en)
    else $error("store written while idle");

  // scrolling always parks the cursor at the start of the bottom row
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCROLL) |-> ((cursor_row == ROW_MAX) && (cursor_col == '0)))
    else $error("cursor not on bottom row during scroll");
`endif

endmodule
